### rtl/core/spa_pkg.sv
// Shared types and constants for the sparse polynomial adder.
// Used by every file of the block except spa_ram; depends on nothing.
package spa_pkg;

  localparam int Terms  = 32;
  localparam int IdxW   = (Terms > 1) ? $clog2(Terms) : 1;
  localparam int CntW   = $clog2(Terms + 1);
  localparam int KindW  = 2;
  localparam int CoefW  = 32;
  localparam int ExpW   = 16;
  localparam int SumW   = CoefW + 1;
  localparam int EntryW = CoefW + ExpW;

  typedef logic [KindW-1:0] kind_t;
  localparam kind_t KindFirst  = 2'd0;
  localparam kind_t KindSecond = 2'd1;
  localparam kind_t KindSum    = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SORT_INIT, ST_RD_I, ST_LD_I, ST_CMP, ST_WR_I,
    ST_MRG_INIT, ST_MRG_RD, ST_MRG_EV, ST_FIN
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_SORT_INIT, OP_RD_I, OP_LD_I, OP_CMP, OP_WR_I,
    OP_MRG_INIT, OP_MRG_RD, OP_MRG_EV, OP_FIN
  } op_t;

  typedef struct packed {
    op_t  op;
    logic sel;
  } cmd_t;

  typedef struct packed {
    logic short_store;
    logic i_last;
    logic j_last;
    logic merge_done;
    logic out_free;
  } sts_t;

endpackage

### rtl/core/spa_item_if.sv
// Input channel of the sparse polynomial adder: term loads and sum requests.
// Depends on spa_pkg for field widths.
interface spa_item_if;
  logic                              valid;
  logic                              ready;
  logic [spa_pkg::KindW-1:0]         kind;
  logic signed [spa_pkg::CoefW-1:0]  coefficient;
  logic signed [spa_pkg::ExpW-1:0]   exponent;

  modport source(output valid, kind, coefficient, exponent, input ready);
  modport sink(input valid, kind, coefficient, exponent, output ready);
endinterface

### rtl/core/spa_result_if.sv
// Output channel of the sparse polynomial adder: one sum term per transaction.
// Depends on spa_pkg for field widths.
interface spa_result_if;
  logic                              valid;
  logic                              ready;
  logic signed [spa_pkg::SumW-1:0]   sum_coefficient;
  logic signed [spa_pkg::ExpW-1:0]   sum_exponent;
  logic                              last_term;
  logic                              empty_sum;
  logic                              dropped_terms;

  modport source(output valid, sum_coefficient, sum_exponent, last_term, empty_sum,
                 dropped_terms, input ready);
  modport sink(input valid, sum_coefficient, sum_exponent, last_term, empty_sum,
               dropped_terms, output ready);
endinterface

### rtl/core/spa_ram.sv
// Generic single write port RAM with one registered read port.
// Standalone; no package needed.
module spa_ram #(
  parameter int Width = 8,
  parameter int Depth = 4
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr,
  input  logic [Width-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr,
  output logic [Width-1:0]                          rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

### rtl/core/spa_ctrl.sv
// Sequencer for loading, sorting and merging of the sparse polynomial adder.
// Depends on spa_pkg; drives the datapath through cmd_t and reads sts_t.
module spa_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  spa_pkg::kind_t      in_kind,
  output logic                in_ready,
  output spa_pkg::cmd_t       cmd,
  input  spa_pkg::sts_t       sts
);
  spa_pkg::state_t state, state_next;
  logic            sel, sel_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= spa_pkg::ST_IDLE;
      sel   <= 1'b0;
    end else begin
      state <= state_next;
      sel   <= sel_next;
    end
  end

  always_comb begin
    state_next = state;
    sel_next   = sel;
    unique case (state)
      spa_pkg::ST_IDLE: begin
        if (in_valid && in_kind == spa_pkg::KindSum) begin
          state_next = spa_pkg::ST_SORT_INIT;
          sel_next   = 1'b0;
        end
      end
      spa_pkg::ST_SORT_INIT: begin
        if (!sts.short_store) begin
          state_next = spa_pkg::ST_RD_I;
        end else if (!sel) begin
          sel_next = 1'b1;
        end else begin
          state_next = spa_pkg::ST_MRG_INIT;
        end
      end
      spa_pkg::ST_RD_I: state_next = spa_pkg::ST_LD_I;
      spa_pkg::ST_LD_I: state_next = spa_pkg::ST_CMP;
      spa_pkg::ST_CMP: begin
        if (sts.j_last) begin
          state_next = spa_pkg::ST_WR_I;
        end
      end
      spa_pkg::ST_WR_I: begin
        if (!sts.i_last) begin
          state_next = spa_pkg::ST_RD_I;
        end else if (!sel) begin
          state_next = spa_pkg::ST_SORT_INIT;
          sel_next   = 1'b1;
        end else begin
          state_next = spa_pkg::ST_MRG_INIT;
        end
      end
      spa_pkg::ST_MRG_INIT: state_next = spa_pkg::ST_MRG_RD;
      spa_pkg::ST_MRG_RD: begin
        state_next = sts.merge_done ? spa_pkg::ST_FIN : spa_pkg::ST_MRG_EV;
      end
      spa_pkg::ST_MRG_EV: begin
        if (sts.out_free) begin
          state_next = spa_pkg::ST_MRG_RD;
        end
      end
      spa_pkg::ST_FIN: begin
        if (sts.out_free) begin
          state_next = spa_pkg::ST_IDLE;
        end
      end
      default: state_next = spa_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state == spa_pkg::ST_IDLE);
    cmd.sel  = sel;
    cmd.op   = spa_pkg::OP_NONE;
    unique case (state)
      spa_pkg::ST_IDLE: begin
        if (in_valid && (in_kind == spa_pkg::KindFirst || in_kind == spa_pkg::KindSecond)) begin
          cmd.op = spa_pkg::OP_LOAD;
        end
      end
      spa_pkg::ST_SORT_INIT: cmd.op = spa_pkg::OP_SORT_INIT;
      spa_pkg::ST_RD_I:      cmd.op = spa_pkg::OP_RD_I;
      spa_pkg::ST_LD_I:      cmd.op = spa_pkg::OP_LD_I;
      spa_pkg::ST_CMP:       cmd.op = spa_pkg::OP_CMP;
      spa_pkg::ST_WR_I:      cmd.op = spa_pkg::OP_WR_I;
      spa_pkg::ST_MRG_INIT:  cmd.op = spa_pkg::OP_MRG_INIT;
      spa_pkg::ST_MRG_RD:    cmd.op = spa_pkg::OP_MRG_RD;
      spa_pkg::ST_MRG_EV:    cmd.op = spa_pkg::OP_MRG_EV;
      spa_pkg::ST_FIN:       cmd.op = spa_pkg::OP_FIN;
      default:               cmd.op = spa_pkg::OP_NONE;
    endcase
  end
endmodule

### rtl/core/spa_dp.sv
// Datapath of the sparse polynomial adder: two term stores, sort and merge
// registers, the pending term and the output register. Depends on spa_pkg, spa_ram.
module spa_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  spa_pkg::cmd_t                     cmd,
  output spa_pkg::sts_t                     sts,
  input  spa_pkg::kind_t                    in_kind,
  input  logic signed [spa_pkg::CoefW-1:0]  in_coef,
  input  logic signed [spa_pkg::ExpW-1:0]   in_exp,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [spa_pkg::SumW-1:0]   out_coef,
  output logic signed [spa_pkg::ExpW-1:0]   out_exp,
  output logic                              out_last,
  output logic                              out_empty,
  output logic                              out_dropped
);
  localparam int CntW  = spa_pkg::CntW;
  localparam int IdxW  = spa_pkg::IdxW;
  localparam int ExpW  = spa_pkg::ExpW;
  localparam int CoefW = spa_pkg::CoefW;
  localparam int SumW  = spa_pkg::SumW;
  localparam int EntW  = spa_pkg::EntryW;

  logic [CntW-1:0] cnt0, cnt1, i, j, a, b, n_sel, load_cnt;
  logic            overflow;
  logic [EntW-1:0] cur;
  logic            pend_valid;
  logic [SumW-1:0] pend_coef;
  logic [ExpW-1:0] pend_exp;

  logic            we0, we1, re0, re1;
  logic [IdxW-1:0] waddr0, waddr1, raddr0, raddr1;
  logic [EntW-1:0] wdata0, wdata1, rdata0, rdata1, rd_sel;

  logic            load_second, load_full, load_nz, swap, out_free;
  logic            has_a, has_b, emit, adv_a, adv_b;
  logic            out_load;
  logic signed [ExpW-1:0]  ea, eb;
  logic signed [SumW-1:0]  xa, xb, sum_ab;
  logic [SumW-1:0] new_coef;
  logic [ExpW-1:0] new_exp;

  spa_ram #(.Width(EntW), .Depth(spa_pkg::Terms)) u_ram0 (
    .clk(clk), .we(we0), .waddr(waddr0), .wdata(wdata0),
    .re(re0), .raddr(raddr0), .rdata(rdata0)
  );
  spa_ram #(.Width(EntW), .Depth(spa_pkg::Terms)) u_ram1 (
    .clk(clk), .we(we1), .waddr(waddr1), .wdata(wdata1),
    .re(re1), .raddr(raddr1), .rdata(rdata1)
  );

  assign n_sel       = cmd.sel ? cnt1 : cnt0;
  assign rd_sel      = cmd.sel ? rdata1 : rdata0;
  assign load_second = (in_kind == spa_pkg::KindSecond);
  assign load_cnt    = load_second ? cnt1 : cnt0;
  assign load_full   = (load_cnt >= CntW'(spa_pkg::Terms));
  assign load_nz     = (in_coef != '0);
  assign swap        = ($signed(cur[ExpW-1:0]) < $signed(rd_sel[ExpW-1:0]));
  assign out_free    = !out_valid || out_ready;
  assign has_a       = (a < cnt0);
  assign has_b       = (b < cnt1);
  assign out_load    = out_free && ((cmd.op == spa_pkg::OP_MRG_EV && emit && pend_valid) ||
                                    cmd.op == spa_pkg::OP_FIN);

  assign sts.short_store = ({1'b0, n_sel} < (CntW + 1)'(2));
  assign sts.i_last      = (({1'b0, i} + (CntW + 1)'(2)) >= {1'b0, n_sel});
  assign sts.j_last      = (({1'b0, j} + (CntW + 1)'(1)) >= {1'b0, n_sel});
  assign sts.merge_done  = !has_a && !has_b;
  assign sts.out_free    = out_free;

  // Store read and write ports; sort passes touch only the selected store.
  always_comb begin
    logic [CntW-1:0] ip1, jp1;
    ip1    = i + CntW'(1);
    jp1    = j + CntW'(1);
    we0    = 1'b0;
    we1    = 1'b0;
    re0    = 1'b0;
    re1    = 1'b0;
    waddr0 = i[IdxW-1:0];
    waddr1 = i[IdxW-1:0];
    wdata0 = cur;
    wdata1 = cur;
    raddr0 = i[IdxW-1:0];
    raddr1 = i[IdxW-1:0];
    unique case (cmd.op)
      spa_pkg::OP_LOAD: begin
        waddr0 = load_cnt[IdxW-1:0];
        waddr1 = load_cnt[IdxW-1:0];
        wdata0 = {in_coef, in_exp};
        wdata1 = {in_coef, in_exp};
        we0    = load_nz && !load_full && !load_second;
        we1    = load_nz && !load_full && load_second;
      end
      spa_pkg::OP_RD_I: begin
        re0 = !cmd.sel;
        re1 = cmd.sel;
      end
      spa_pkg::OP_LD_I: begin
        re0    = !cmd.sel;
        re1    = cmd.sel;
        raddr0 = ip1[IdxW-1:0];
        raddr1 = ip1[IdxW-1:0];
      end
      spa_pkg::OP_CMP: begin
        waddr0 = j[IdxW-1:0];
        waddr1 = j[IdxW-1:0];
        we0    = swap && !cmd.sel;
        we1    = swap && cmd.sel;
        raddr0 = jp1[IdxW-1:0];
        raddr1 = jp1[IdxW-1:0];
        re0    = !sts.j_last && !cmd.sel;
        re1    = !sts.j_last && cmd.sel;
      end
      spa_pkg::OP_WR_I: begin
        we0 = !cmd.sel;
        we1 = cmd.sel;
      end
      spa_pkg::OP_MRG_RD: begin
        raddr0 = a[IdxW-1:0];
        raddr1 = b[IdxW-1:0];
        re0    = 1'b1;
        re1    = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // One merge step on the current heads of both stores.
  always_comb begin
    ea     = $signed(rdata0[ExpW-1:0]);
    eb     = $signed(rdata1[ExpW-1:0]);
    xa     = $signed({rdata0[EntW-1], rdata0[EntW-1:ExpW]});
    xb     = $signed({rdata1[EntW-1], rdata1[EntW-1:ExpW]});
    sum_ab = xa + xb;
    priority if (has_a && has_b && ea == eb) begin
      new_coef = sum_ab;
      new_exp  = ea;
      emit     = (sum_ab != '0);
      adv_a    = 1'b1;
      adv_b    = 1'b1;
    end else if (has_a && (!has_b || ea > eb)) begin
      new_coef = xa;
      new_exp  = ea;
      emit     = 1'b1;
      adv_a    = 1'b1;
      adv_b    = 1'b0;
    end else begin
      new_coef = xb;
      new_exp  = eb;
      emit     = 1'b1;
      adv_a    = 1'b0;
      adv_b    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt0       <= '0;
      cnt1       <= '0;
      overflow   <= 1'b0;
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && !out_load) begin
        out_valid <= 1'b0;
      end
      unique case (cmd.op)
        spa_pkg::OP_LOAD: begin
          if (load_nz) begin
            if (load_full) begin
              overflow <= 1'b1;
            end else if (load_second) begin
              cnt1 <= cnt1 + CntW'(1);
            end else begin
              cnt0 <= cnt0 + CntW'(1);
            end
          end
        end
        spa_pkg::OP_SORT_INIT: i <= '0;
        spa_pkg::OP_LD_I: begin
          cur <= rd_sel;
          j   <= i + CntW'(1);
        end
        spa_pkg::OP_CMP: begin
          if (swap) begin
            cur <= rd_sel;
          end
          j <= j + CntW'(1);
        end
        spa_pkg::OP_WR_I: i <= i + CntW'(1);
        spa_pkg::OP_MRG_INIT: begin
          a          <= '0;
          b          <= '0;
          pend_valid <= 1'b0;
        end
        spa_pkg::OP_MRG_EV: begin
          if (out_free) begin
            a <= a + CntW'(adv_a);
            b <= b + CntW'(adv_b);
            // The newest term is held back until the next one shows it is not last.
            if (emit) begin
              if (pend_valid) begin
                out_valid   <= 1'b1;
                out_coef    <= pend_coef;
                out_exp     <= pend_exp;
                out_last    <= 1'b0;
                out_empty   <= 1'b0;
                out_dropped <= overflow;
              end
              pend_coef  <= new_coef;
              pend_exp   <= new_exp;
              pend_valid <= 1'b1;
            end
          end
        end
        spa_pkg::OP_FIN: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            out_coef    <= pend_valid ? pend_coef : '0;
            out_exp     <= pend_valid ? pend_exp : '0;
            out_last    <= 1'b1;
            out_empty   <= !pend_valid;
            out_dropped <= overflow;
            cnt0        <= '0;
            cnt1        <= '0;
            overflow    <= 1'b0;
            pend_valid  <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt0 <= CntW'(spa_pkg::Terms) && cnt1 <= CntW'(spa_pkg::Terms))
    else $error("store count beyond capacity");

  a_fin_clears: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == spa_pkg::OP_FIN && out_free) |=>
      (cnt0 == '0 && cnt1 == '0 && !overflow && out_valid && out_last))
    else $error("final term did not clear the stores");

  a_merge_idx: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == spa_pkg::OP_MRG_EV) |-> (a <= cnt0 && b <= cnt1 && (has_a || has_b)))
    else $error("merge index out of range");

  a_cmp_idx: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == spa_pkg::OP_CMP) |-> (j < n_sel && j > i))
    else $error("sort inner index out of range");
endmodule

### rtl/core/sparse_polynomial_adder_unit.sv
// Top level of the sparse polynomial adder: sequencer plus datapath.
// Depends on spa_pkg, spa_item_if, spa_result_if, spa_ctrl, spa_dp.
//
//   port     role    fields
//   items    sink    kind, coefficient, exponent
//   results  source  sum_coefficient, sum_exponent, last_term, empty_sum, dropped_terms
//
// Items are taken only while no sum is in progress. A sum request sorts each store with
// a single-port pass, then merges; each merge step is a RAM read and then an evaluate.
// The final term enters the output register in the finish state after the merge ends.
// Reset is synchronous; both stores start empty. A stalled results channel holds the merge.
module sparse_polynomial_adder_unit (
  input  logic         clk,
  input  logic         rst,
  spa_item_if.sink     items,
  spa_result_if.source results
);
  spa_pkg::cmd_t cmd;
  spa_pkg::sts_t sts;

  spa_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(items.valid), .in_kind(items.kind), .in_ready(items.ready),
    .cmd(cmd), .sts(sts)
  );

  spa_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .in_kind(items.kind), .in_coef(items.coefficient), .in_exp(items.exponent),
    .out_valid(results.valid), .out_ready(results.ready),
    .out_coef(results.sum_coefficient), .out_exp(results.sum_exponent),
    .out_last(results.last_term), .out_empty(results.empty_sum),
    .out_dropped(results.dropped_terms)
  );
endmodule

### tb/sv/tb_spa_if.sv
// Testbench-side note: the channel interfaces come from the RTL (spa_item_if, spa_result_if).
// This file holds the term record used by the polynomial predictor; depends on spa_pkg.
package tb_spa_types;
  import spa_pkg::*;

  typedef struct {
    logic signed [SumW-1:0] coef;
    logic signed [ExpW-1:0] expo;
    logic                   last;
    logic                   empty;
    logic                   dropped;
  } sum_term_t;
endpackage

### tb/sv/tb_top.sv
// Self-checking bench for sparse_polynomial_adder_unit: loads two polynomials,
// predicts the sorted merged sum in the bench and compares every sum term.
// Depends on spa_pkg, spa_item_if, spa_result_if and tb_spa_types.
module tb_top;
  import spa_pkg::*;
  import tb_spa_types::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  spa_item_if   items();
  spa_result_if results();

  sparse_polynomial_adder_unit DUT (.clk(clk), .rst(rst), .items(items), .results(results));

  initial begin
    forever #1 clk = ~clk;
  end

  // Predictor state.
  logic signed [CoefW-1:0] poly_coef [2][Terms];
  logic signed [ExpW-1:0]  poly_exp  [2][Terms];
  int                      poly_count [2];
  bit                      poly_overflow;
  sum_term_t               sum_queue [$];

  int  mismatches = 0;
  int  terms_checked = 0;
  int  sums_requested = 0;
  int  items_sent = 0;
  int  hold_off = 0;
  bit  rx_random = 1'b1;

  initial begin
    items.valid = 1'b0;
    items.kind = KindFirst;
    items.coefficient = '0;
    items.exponent = '0;
    results.ready = 1'b0;
    poly_count[0] = 0;
    poly_count[1] = 0;
    poly_overflow = 1'b0;
  end

  task automatic sort_poly(input int p);
    logic signed [CoefW-1:0] tc;
    logic signed [ExpW-1:0]  te;
    for (int i = 0; i + 1 < poly_count[p]; i++)
      for (int j = i + 1; j < poly_count[p]; j++)
        if (poly_exp[p][i] < poly_exp[p][j]) begin
          tc = poly_coef[p][i]; te = poly_exp[p][i];
          poly_coef[p][i] = poly_coef[p][j]; poly_exp[p][i] = poly_exp[p][j];
          poly_coef[p][j] = tc; poly_exp[p][j] = te;
        end
  endtask

  task automatic push_term(input logic signed [SumW-1:0] c, input logic signed [ExpW-1:0] e,
                           inout int n);
    sum_term_t t;
    t.coef = c; t.expo = e; t.last = 1'b0; t.empty = 1'b0; t.dropped = poly_overflow;
    sum_queue.push_back(t);
    n++;
  endtask

  // Updates the predictor for one accepted transaction.
  task automatic predict_item(input kind_t k, input logic signed [CoefW-1:0] c,
                              input logic signed [ExpW-1:0] e);
    int a, b, n, p;
    logic signed [SumW-1:0] s;
    sum_term_t t;
    a = 0; b = 0; n = 0;
    if (k == KindFirst || k == KindSecond) begin
      p = (k == KindFirst) ? 0 : 1;
      if (c != 0) begin
        if (poly_count[p] >= Terms) poly_overflow = 1'b1;
        else begin
          poly_coef[p][poly_count[p]] = c;
          poly_exp[p][poly_count[p]] = e;
          poly_count[p]++;
        end
      end
    end else if (k == KindSum) begin
      sums_requested++;
      sort_poly(0);
      sort_poly(1);
      while (a < poly_count[0] && b < poly_count[1]) begin
        if (poly_exp[0][a] == poly_exp[1][b]) begin
          s = SumW'(poly_coef[0][a]) + SumW'(poly_coef[1][b]);
          if (s != 0) push_term(s, poly_exp[0][a], n);
          a++; b++;
        end else if (poly_exp[0][a] > poly_exp[1][b]) begin
          push_term(SumW'(poly_coef[0][a]), poly_exp[0][a], n); a++;
        end else begin
          push_term(SumW'(poly_coef[1][b]), poly_exp[1][b], n); b++;
        end
      end
      while (b < poly_count[1]) begin
        push_term(SumW'(poly_coef[1][b]), poly_exp[1][b], n); b++;
      end
      while (a < poly_count[0]) begin
        push_term(SumW'(poly_coef[0][a]), poly_exp[0][a], n); a++;
      end
      if (n == 0) begin
        t.coef = '0; t.expo = '0; t.last = 1'b1; t.empty = 1'b1; t.dropped = poly_overflow;
        sum_queue.push_back(t);
      end else begin
        sum_queue[sum_queue.size() - 1].last = 1'b1;
      end
      poly_count[0] = 0;
      poly_count[1] = 0;
      poly_overflow = 1'b0;
    end
  endtask

  // Sends one transaction after a random gap unless no_gap is set; the predictor runs on acceptance.
  task automatic send_item(input kind_t k, input logic signed [CoefW-1:0] c,
                           input logic signed [ExpW-1:0] e, input bit no_gap = 1'b0);
    int gap;
    gap = no_gap ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16));
    if (!no_gap && $urandom_range(0, 1)) gap = 0;
    if (gap > 0) begin
      items.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    items.valid <= 1'b1;
    items.kind <= k;
    items.coefficient <= c;
    items.exponent <= e;
    @(posedge clk);
    while (!items.ready) @(posedge clk);
    items_sent++;
    predict_item(k, c, e);
  endtask

  task automatic go_idle();
    items.valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic signed [CoefW-1:0] rand_coef();
    case ($urandom_range(0, 5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $urandom_range(0, 1) ? 32'sd256 : -32'sd256;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic signed [ExpW-1:0] rand_exp(input bit narrow);
    if (narrow) return ExpW'($signed($urandom_range(0, 12)) - 6);
    return ExpW'($urandom());
  endfunction

  // Result checker; the receiver below stalls throughout a hold-off, and otherwise at random while rx_random is set.
  always @(posedge clk) begin
    sum_term_t want;
    if (!rst && results.valid && results.ready) begin
      if (sum_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected sum term: coef=%0d exp=%0d", results.sum_coefficient,
                   results.sum_exponent);
      end else begin
        want = sum_queue.pop_front();
        terms_checked++;
        if (results.sum_coefficient !== want.coef || results.sum_exponent !== want.expo ||
            results.last_term !== want.last || results.empty_sum !== want.empty ||
            results.dropped_terms !== want.dropped) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"sum term mismatch: exp coef=%0d exp=%0d last=%b empty=%b drop=%b,",
                      " got coef=%0d exp=%0d last=%b empty=%b drop=%b"},
                     want.coef, want.expo, want.last, want.empty, want.dropped,
                     results.sum_coefficient, results.sum_exponent, results.last_term,
                     results.empty_sum, results.dropped_terms);
        end
      end
    end
  end

  int rx_wait = 0;
  always @(posedge clk) begin
    if (rst) begin
      results.ready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      results.ready <= 1'b0;
    end else if (!rx_random) begin
      results.ready <= 1'b1;
    end else if (rx_wait > 0) begin
      rx_wait <= rx_wait - 1;
      results.ready <= 1'b0;
    end else if (results.ready && results.valid) begin
      rx_wait <= $urandom_range(0, 1) ? 0 : $urandom_range(0, 16);
      results.ready <= 1'b0;
    end else begin
      results.ready <= 1'b1;
    end
  end

  task automatic wait_drained();
    while (sum_queue.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic test_edges();
    send_item(KindSum, 0, 0);                        // empty sum
    send_item(KindFirst, 0, 5);                      // zero coefficient ignored
    send_item(KindSecond, 0, -5);
    send_item(KindSum, 0, 0);
    send_item(KindFirst, 32'sh7fffffff, 16'sh7fff);
    send_item(KindSecond, 32'sh7fffffff, 16'sh7fff); // largest positive sum
    send_item(KindFirst, 32'sh80000000, 16'sh8000);
    send_item(KindSecond, 32'sh80000000, 16'sh8000); // most negative sum
    send_item(KindFirst, 300, 3);
    send_item(KindSecond, -300, 3);                  // cancels and drops
    send_item(KindFirst, 7, 1);
    send_item(KindFirst, 9, 1);                      // repeated exponent in one store
    send_item(KindSecond, 4, 2);
    items.valid <= 1'b1; items.kind <= 2'd3;         // kind three is ignored
    items.coefficient <= 32'sh5a5a5a5a; items.exponent <= 16'sh0a5a;
    @(posedge clk);
    while (!items.ready) @(posedge clk);
    send_item(KindSum, 0, 0);
    send_item(KindSecond, -1, -1);
    send_item(KindSum, 0, 0);                        // only the second store
    go_idle();
    wait_drained();
  endtask

  task automatic test_overflow();
    for (int i = 0; i < Terms + 3; i++)
      send_item(KindFirst, rand_coef() | 1, rand_exp(1'b0), 1'b1);
    send_item(KindSecond, 256, 0);
    send_item(KindSum, 0, 0);
    for (int i = 0; i < Terms; i++)
      send_item(KindSecond, rand_coef() | 1, rand_exp(1'b1), 1'b1);
    send_item(KindSecond, 5, 5, 1'b1);
    send_item(KindFirst, 3, 3);
    send_item(KindSum, 0, 0);
    send_item(KindSum, 0, 0);                        // flag cleared after a sum
    go_idle();
    wait_drained();
  endtask

  task automatic test_random(input int n_items);
    int sent, len;
    bit narrow;
    sent = 0;
    while (sent < n_items) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 10);
      narrow = $urandom_range(0, 1);
      for (int i = 0; i < len; i++) begin
        send_item($urandom_range(0, 1) ? KindFirst : KindSecond,
                  ($urandom_range(0, 15) == 0) ? 32'sd0 : rand_coef(), rand_exp(narrow));
        sent++;
      end
      send_item(KindSum, $urandom(), ExpW'($urandom()));
      sent++;
    end
    go_idle();
    wait_drained();
  endtask

  // Receiver blocks for a long stretch while the sender keeps loading and summing.
  task automatic test_backpressure();
    hold_off = 400;
    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < 6; i++)
        send_item($urandom_range(0, 1) ? KindFirst : KindSecond, rand_coef() | 1,
                  rand_exp(1'b1), 1'b1);
      send_item(KindSum, 0, 0, 1'b1);
    end
    go_idle();
    wait_drained();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_edges();
    test_overflow();
    test_random(130);
    rx_random = 1'b0;
    test_random(50);
    rx_random = 1'b1;
    test_backpressure();
    test_random(110);
    $display("Sent %0d items, %0d sum requests; checked %0d sum terms.", items_sent,
             sums_requested, terms_checked);
    $display("Covered empty sums, cancellation, store overflow and a long output stall.");
    if (mismatches == 0 && sum_queue.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches, %0d terms still expected", mismatches, sum_queue.size());
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("timeout with %0d terms still expected", sum_queue.size());
    $display("end of test: mismatches");
    $finish;
  end
endmodule
